### sv/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// shared constants and types of the remote command frame decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcfd_pkg;

  localparam int unsigned FRAME_LENGTH = 12;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned NUM_CH       = 4;
  localparam int unsigned CH_W         = 11;
  localparam int unsigned PAYLOAD_LEN  = 7;

  localparam logic [7:0] HDR0 = 8'h24;  // '$'
  localparam logic [7:0] HDR1 = 8'h4D;  // 'M'
  localparam logic [7:0] HDR2 = 8'h3C;  // '<'

  localparam logic [POS_W-1:0] POS_HDR0 = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HDR2 = POS_W'(2);
  localparam logic [POS_W-1:0] POS_BODY = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CSUM = POS_W'(FRAME_LENGTH - 1);

  localparam logic [CH_W-1:0] CH_LOW = CH_W'(1000);
  localparam logic [CH_W-1:0] CH_MID = CH_W'(1500);

  typedef enum logic [7:0] {
    CMD_MOTOR   = 8'd0,
    CMD_STICK   = 8'd1,
    CMD_ARM     = 8'd2,
    CMD_DISARM  = 8'd3,
    CMD_CAL     = 8'd4,
    CMD_LED     = 8'd5,
    CMD_COLOR   = 8'd6,
    CMD_ALT_ON  = 8'd7,
    CMD_ALT_OFF = 8'd8,
    CMD_BEEP    = 8'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_APPLIED  = 2'd0,
    ST_BAD_CSUM = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_t;

  // payload[0..3] channels, [4] led, [5] color, [6] beep
  typedef struct packed {
    logic [7:0]                  cmd;
    logic [PAYLOAD_LEN-1:0][7:0] payload;
    logic                        csum_ok;
  } frame_t;

endpackage

### sv/rcfd_framer.sv
// ----------------------------------------------------------------------------
// rcfd_framer
// header hunt, body capture and xor check; hands one frame per checksum byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcfd_framer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  input  logic                  adv,
  output logic                  frame_valid,
  output rcfd_pkg::frame_t      frame
);

  logic [rcfd_pkg::POS_W-1:0] pos;
  logic [rcfd_pkg::POS_W-1:0] pos_next;
  logic [7:0]                 rxor;
  logic [7:0]                 rxor_next;
  logic [7:0]                 body [rcfd_pkg::PAYLOAD_LEN+1];
  logic [rcfd_pkg::POS_W-1:0] body_off;
  logic                       accept;
  logic                       in_body;
  logic                       complete;
  rcfd_pkg::frame_t           frame_next;

  assign in_stall = frame_valid && !adv;
  assign accept   = in_valid && !in_stall;
  assign in_body  = (pos >= rcfd_pkg::POS_BODY) && (pos < rcfd_pkg::POS_CSUM);
  assign body_off = pos - rcfd_pkg::POS_BODY;

  always_comb begin
    pos_next  = pos;
    rxor_next = rxor;
    complete  = 1'b0;
    if (accept) begin
      if (pos == rcfd_pkg::POS_HDR0) begin
        pos_next = (rx_byte == rcfd_pkg::HDR0) ? rcfd_pkg::POS_HDR1 : rcfd_pkg::POS_HDR0;
      end else if (pos == rcfd_pkg::POS_HDR1) begin
        pos_next = (rx_byte == rcfd_pkg::HDR1) ? rcfd_pkg::POS_HDR2 : rcfd_pkg::POS_HDR0;
      end else if (pos == rcfd_pkg::POS_HDR2) begin
        pos_next = (rx_byte == rcfd_pkg::HDR2) ? rcfd_pkg::POS_BODY : rcfd_pkg::POS_HDR0;
      end else if (in_body) begin
        pos_next  = pos + rcfd_pkg::POS_W'(1);
        rxor_next = (pos == rcfd_pkg::POS_BODY) ? rx_byte : (rxor ^ rx_byte);
      end else begin
        pos_next  = rcfd_pkg::POS_HDR0;
        rxor_next = 8'h00;
        complete  = 1'b1;
      end
    end
  end

  always_comb begin
    frame_next.cmd     = body[0];
    frame_next.csum_ok = (rxor == rx_byte);
    for (int k = 0; k < rcfd_pkg::PAYLOAD_LEN; k++) begin
      frame_next.payload[k] = body[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= rcfd_pkg::POS_HDR0;
      rxor        <= 8'h00;
      frame_valid <= 1'b0;
    end else begin
      pos         <= pos_next;
      rxor        <= rxor_next;
      frame_valid <= complete || (frame_valid && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_body) begin
      body[body_off[2:0]] <= rx_byte;
    end
    if (complete) begin
      frame <= frame_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_csum_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && pos == rcfd_pkg::POS_CSUM |=> pos == rcfd_pkg::POS_HDR0 && frame_valid)
    else $error("checksum byte did not close the frame");

  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !adv |=> frame_valid && $stable(frame))
    else $error("pending frame lost or changed");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= rcfd_pkg::POS_CSUM)
    else $error("byte position out of frame");
`endif

endmodule

### sv/rcfd_exec.sv
// ----------------------------------------------------------------------------
// rcfd_exec
// applies a checked frame to the kept remote state and holds the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcfd_exec (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        frame_valid,
  input  rcfd_pkg::frame_t            frame,
  output logic                        adv,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rcfd_pkg::CH_W-1:0]   motor_roll,
  output logic [rcfd_pkg::CH_W-1:0]   motor_pitch,
  output logic [rcfd_pkg::CH_W-1:0]   motor_throttle,
  output logic [rcfd_pkg::CH_W-1:0]   motor_yaw,
  output logic                        armed,
  output logic                        direct_motor_mode,
  output logic                        calibrate_request,
  output logic                        altitude_hold,
  output logic [7:0]                  led_mode,
  output logic [7:0]                  color_value,
  output logic [7:0]                  beep_value,
  output logic [1:0]                  frame_status
);

  logic [rcfd_pkg::NUM_CH-1:0][rcfd_pkg::CH_W-1:0] ch, ch_next;
  logic             arm, arm_next;
  logic             dmode, dmode_next;
  logic             cal, cal_next;
  logic             alt, alt_next;
  logic [7:0]       led, led_next;
  logic [7:0]       color, color_next;
  logic [7:0]       beep, beep_next;
  rcfd_pkg::status_t status, status_next;
  logic             fire;

  assign adv  = !out_valid || !out_stall;
  assign fire = frame_valid && adv;

  always_comb begin
    ch_next     = ch;
    arm_next    = arm;
    dmode_next  = dmode;
    cal_next    = cal;
    alt_next    = alt;
    led_next    = led;
    color_next  = color;
    beep_next   = beep;
    status_next = rcfd_pkg::ST_APPLIED;
    if (!frame.csum_ok) begin
      status_next = rcfd_pkg::ST_BAD_CSUM;
    end else begin
      case (frame.cmd)
        rcfd_pkg::CMD_MOTOR, rcfd_pkg::CMD_STICK: begin
          for (int k = 0; k < rcfd_pkg::NUM_CH; k++) begin
            ch_next[k] = rcfd_pkg::CH_LOW
                       + {1'b0, frame.payload[k], 2'b00};
          end
          dmode_next = (frame.cmd == rcfd_pkg::CMD_MOTOR);
        end
        rcfd_pkg::CMD_ARM: begin
          if (!arm) begin
            arm_next   = 1'b1;
            dmode_next = 1'b0;
            ch_next    = {rcfd_pkg::CH_LOW, rcfd_pkg::CH_MID,
                          rcfd_pkg::CH_MID, rcfd_pkg::CH_MID};
          end
        end
        rcfd_pkg::CMD_DISARM: begin
          arm_next = 1'b0;
          ch_next  = {rcfd_pkg::NUM_CH{rcfd_pkg::CH_LOW}};
        end
        rcfd_pkg::CMD_CAL:     cal_next   = 1'b1;
        rcfd_pkg::CMD_LED:     led_next   = frame.payload[4];
        rcfd_pkg::CMD_COLOR:   color_next = frame.payload[5];
        rcfd_pkg::CMD_ALT_ON:  alt_next   = 1'b1;
        rcfd_pkg::CMD_ALT_OFF: alt_next   = 1'b0;
        rcfd_pkg::CMD_BEEP:    beep_next  = frame.payload[6];
        default:               status_next = rcfd_pkg::ST_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch        <= {rcfd_pkg::NUM_CH{rcfd_pkg::CH_LOW}};
      arm       <= 1'b0;
      dmode     <= 1'b0;
      cal       <= 1'b0;
      alt       <= 1'b0;
      led       <= 8'h00;
      color     <= 8'h00;
      beep      <= 8'h00;
      status    <= rcfd_pkg::ST_APPLIED;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        ch     <= ch_next;
        arm    <= arm_next;
        dmode  <= dmode_next;
        cal    <= cal_next;
        alt    <= alt_next;
        led    <= led_next;
        color  <= color_next;
        beep   <= beep_next;
        status <= status_next;
      end
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  assign motor_roll        = ch[0];
  assign motor_pitch       = ch[1];
  assign motor_throttle    = ch[2];
  assign motor_yaw         = ch[3];
  assign armed             = arm;
  assign direct_motor_mode = dmode;
  assign calibrate_request = cal;
  assign altitude_hold     = alt;
  assign led_mode          = led;
  assign color_value       = color;
  assign beep_value        = beep;
  assign frame_status      = status;

`ifndef NO_ASSERTIONS
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    cal |=> cal)
    else $error("calibration request cleared");

  a_bad_csum_no_change: assert property (@(posedge clk) disable iff (rst)
    fire && !frame.csum_ok |=> $stable(ch) && $stable(arm) && $stable(led)
      && status == rcfd_pkg::ST_BAD_CSUM)
    else $error("state changed on checksum mismatch");

  a_arm_only_by_cmd: assert property (@(posedge clk) disable iff (rst)
    !arm && !(fire && frame.csum_ok && frame.cmd == rcfd_pkg::CMD_ARM) |=> !arm)
    else $error("armed without an arm request");
`endif

endmodule

### sv/remote_command_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// remote_command_frame_decoder_unit: one byte accepted per cycle unless
// in_stall; the checksum byte loads the frame register, which then feeds the
// result register; sync reset hunts for the header, channels at 1000
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module remote_command_frame_decoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rcfd_pkg::CH_W-1:0]   motor_roll,
  output logic [rcfd_pkg::CH_W-1:0]   motor_pitch,
  output logic [rcfd_pkg::CH_W-1:0]   motor_throttle,
  output logic [rcfd_pkg::CH_W-1:0]   motor_yaw,
  output logic                        armed,
  output logic                        direct_motor_mode,
  output logic                        calibrate_request,
  output logic                        altitude_hold,
  output logic [7:0]                  led_mode,
  output logic [7:0]                  color_value,
  output logic [7:0]                  beep_value,
  output logic [1:0]                  frame_status
);

  logic             adv;
  logic             frame_valid;
  rcfd_pkg::frame_t frame;

  rcfd_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .adv         (adv),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  rcfd_exec u_exec (
    .clk               (clk),
    .rst               (rst),
    .frame_valid       (frame_valid),
    .frame             (frame),
    .adv               (adv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .motor_roll        (motor_roll),
    .motor_pitch       (motor_pitch),
    .motor_throttle    (motor_throttle),
    .motor_yaw         (motor_yaw),
    .armed             (armed),
    .direct_motor_mode (direct_motor_mode),
    .calibrate_request (calibrate_request),
    .altitude_hold     (altitude_hold),
    .led_mode          (led_mode),
    .color_value       (color_value),
    .beep_value        (beep_value),
    .frame_status      (frame_status)
  );

endmodule
